// ===== rtl/core/rgba_integral_image_macros.svh =====
// Assertion macros used by the integral image top level.
`ifndef RGBA_INTEGRAL_IMAGE_MACROS_SVH
`define RGBA_INTEGRAL_IMAGE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, off while rst_n is low.
`define RGBAII_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, off while rst_n is low.
`define RGBAII_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGBAII_ASSERT_IMP(lbl, ante, cons, msg)
`define RGBAII_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/rgbaii_pkg.sv =====
// Shared types and constants of the RGBA integral image block.
`timescale 1ns / 1ps
package rgbaii_pkg;

  localparam int PIX_W     = 8;   // channel value
  localparam int SQ_W      = 16;  // squared channel value
  localparam int ROW_W     = 27;  // running row sum
  localparam int SUM_W     = 36;  // table value
  localparam int CFG_W     = 11;  // widest config register
  localparam int SIZE_W    = 13;  // holds sizes up to 8191
  localparam int NUM_LANES = 4;   // channel lanes on the ports
  localparam int IDX_W     = 2;   // config register index

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SQUARE_MODE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic             square_mode;
  } cfg_t;

  // Item leaving the accumulate stage
  typedef struct packed {
    logic [NUM_LANES-1:0][ROW_W-1:0] row_sum;
    logic                            first_row;
    logic                            frame_end;
  } acc_item_t;

  // Merge stage control
  typedef struct packed {
    logic accept;  // new pixel enters the accumulate stage
    logic hit;     // that pixel reads the entry being written this cycle
    logic load;    // accumulate stage moves into the output register
  } merge_ctrl_t;

endpackage

// ===== rtl/core/rgbaii_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rgbaii_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rgbaii_accum.sv =====
// Accumulate stage: position counters, per-channel row sums, stage register.
`timescale 1ns / 1ps
module rgbaii_accum #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CHANNELS   = 4,
  parameter int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  rgbaii_pkg::cfg_t                               cfg,
  input  logic                                           accept,
  input  logic [rgbaii_pkg::NUM_LANES-1:0][rgbaii_pkg::PIX_W-1:0] pix,
  output logic [CW-1:0]                                  rd_col,
  output logic [CW-1:0]                                  item_col,
  output rgbaii_pkg::acc_item_t                          item
);
  import rgbaii_pkg::*;

  logic [CW-1:0]     column_count_r, column_count_nxt;
  logic [RW-1:0]     row_count_r, row_count_nxt;
  logic [ROW_W-1:0]  row_sum_r   [NUM_LANES];
  logic [ROW_W-1:0]  row_sum_nxt [NUM_LANES];
  acc_item_t         item_r, item_nxt;
  logic [CW-1:0]     item_col_r;
  logic [SIZE_W-1:0] w_eff, h_eff, col_ext, row_ext;
  logic              row_end, frame_last;

  // Clamp sizes to 1..MAX
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if ({{(SIZE_W-CFG_W){1'b0}}, cfg.frame_width} > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = {{(SIZE_W-CFG_W){1'b0}}, cfg.frame_width};
    end
    if (cfg.frame_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if ({{(SIZE_W-CFG_W){1'b0}}, cfg.frame_height} > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = {{(SIZE_W-CFG_W){1'b0}}, cfg.frame_height};
    end
  end

  assign col_ext    = {{(SIZE_W-CW){1'b0}}, column_count_r};
  assign row_ext    = {{(SIZE_W-RW){1'b0}}, row_count_r};
  assign row_end    = (col_ext + SIZE_W'(1)) >= w_eff;
  assign frame_last = row_end && ((row_ext + SIZE_W'(1)) >= h_eff);

  always_comb begin
    column_count_nxt = row_end ? '0 : CW'(col_ext + SIZE_W'(1));
    row_count_nxt    = row_count_r;
    if (row_end) begin
      row_count_nxt = frame_last ? '0 : RW'(row_ext + SIZE_W'(1));
    end
  end

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      logic [SQ_W-1:0]  v;
      logic [ROW_W-1:0] sum_new;
      assign v = cfg.square_mode ? (SQ_W'(pix[c]) * SQ_W'(pix[c]))
                                 : {{(SQ_W-PIX_W){1'b0}}, pix[c]};
      assign sum_new        = row_sum_r[c] + {{(ROW_W-SQ_W){1'b0}}, v};
      assign row_sum_nxt[c] = row_end ? '0 : sum_new;
      assign item_nxt.row_sum[c] = sum_new;
    end else begin : g_off
      assign row_sum_nxt[c]      = '0;
      assign item_nxt.row_sum[c] = '0;
    end
  end

  assign item_nxt.first_row = (row_count_r == '0);
  assign item_nxt.frame_end = frame_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      for (int c = 0; c < NUM_LANES; c++) begin
        row_sum_r[c] <= '0;
      end
    end else if (accept) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      for (int c = 0; c < NUM_LANES; c++) begin
        row_sum_r[c] <= row_sum_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= item_nxt;
      item_col_r <= column_count_r;
    end
  end

  assign rd_col   = column_count_r;
  assign item_col = item_col_r;
  assign item     = item_r;

endmodule

// ===== rtl/core/rgbaii_merge.sv =====
// Merge stage: adds the row above to the row sums, forwards, output register.
`timescale 1ns / 1ps
module rgbaii_merge #(
  parameter int CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rgbaii_pkg::merge_ctrl_t                ctrl,
  input  rgbaii_pkg::acc_item_t                  item,
  input  logic [CHANNELS*rgbaii_pkg::SUM_W-1:0]  rdata,
  output logic [CHANNELS*rgbaii_pkg::SUM_W-1:0]  wdata,
  output logic [rgbaii_pkg::NUM_LANES*rgbaii_pkg::SUM_W-1:0] sums,
  output logic                                   frame_end
);
  import rgbaii_pkg::*;

  logic                              byp_r;
  logic [CHANNELS*SUM_W-1:0]         byp_data_r;
  logic [NUM_LANES-1:0][SUM_W-1:0]   total;
  logic [NUM_LANES*SUM_W-1:0]        sums_r;
  logic                              frame_end_r;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      logic [SUM_W-1:0] above;
      always_comb begin
        if (item.first_row) begin
          above = '0;
        end else if (byp_r) begin
          above = byp_data_r[c*SUM_W +: SUM_W];
        end else begin
          above = rdata[c*SUM_W +: SUM_W];
        end
      end
      assign total[c] = above + {{(SUM_W-ROW_W){1'b0}}, item.row_sum[c]};
      assign wdata[c*SUM_W +: SUM_W] = total[c];
    end else begin : g_off
      assign total[c] = '0;
    end
  end

  // Forward the entry written in the same cycle it is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (ctrl.accept) begin
      byp_r <= ctrl.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && ctrl.hit) begin
      byp_data_r <= wdata;
    end
    if (ctrl.load) begin
      sums_r      <= total;
      frame_end_r <= item.frame_end;
    end
  end

  assign sums      = sums_r;
  assign frame_end = frame_end_r;

endmodule

// ===== rtl/core/rgba_integral_image.sv =====
// Path: accumulate stage (s1), then output register. Throughput: one pixel per
//   cycle unless the output is blocked; set by the line store, one read and one
//   write port, with the write forwarded when the next pixel reads that column.
// Reset (rst_n low, synchronous): counters, row sums and valids cleared,
//   registers back to 1024 x 1024, plain mode. Line store is not cleared.
// Top level of the RGBA summed-area table (integral image) block.
`timescale 1ns / 1ps
`include "rgba_integral_image_macros.svh"
module rgba_integral_image #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CHANNELS   = 4
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  // Pixel input
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  input  logic [rgbaii_pkg::NUM_LANES*rgbaii_pkg::PIX_W-1:0] in_tdata,
  // Result output
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // [35:0] sum_red, [71:36] sum_green, [107:72] sum_blue, [143:108] sum_alpha
  output logic [rgbaii_pkg::NUM_LANES*rgbaii_pkg::SUM_W-1:0] out_tdata,
  output logic                                           out_tlast,   // frame_end
  // Register writes
  input  logic                                           cfg_we,
  input  logic [rgbaii_pkg::IDX_W-1:0]                   cfg_index,
  input  logic [rgbaii_pkg::CFG_W-1:0]                   cfg_wdata
);
  import rgbaii_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Config registers; changes take effect on the next pixel.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_wdata;
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_wdata;
        REG_SQUARE_MODE:  cfg_nxt.square_mode  = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= CFG_W'(1024);
      cfg_r.frame_height <= CFG_W'(1024);
      cfg_r.square_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Two-stage pipe: accumulate stage (s1), then output register.
  // s1 moves on whenever the output register is empty or being drained,
  // so the input stalls only when s1 is full and the output is blocked.
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv, in_xfer;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Accumulate stage
  logic [CW-1:0] rd_col, s1_col;
  acc_item_t     s1_item;

  rgbaii_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS),
    .CW         (CW)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (in_xfer),
    .pix      (in_tdata),
    .rd_col   (rd_col),
    .item_col (s1_col),
    .item     (s1_item)
  );

  // Line store: one row of table values per column, all channels side by
  // side. Read as the pixel is transferred, written back as it leaves s1.
  logic [CHANNELS*SUM_W-1:0] ram_rdata, ram_wdata;

  rgbaii_ram #(
    .WIDTH (CHANNELS*SUM_W),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (rd_col),
    .rdata (ram_rdata)
  );

  // Merge stage and output register
  merge_ctrl_t mctrl;

  assign mctrl.accept = in_xfer;
  assign mctrl.hit    = s1_adv && (s1_col == rd_col);  // narrow frames
  assign mctrl.load   = s1_adv;

  rgbaii_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctrl),
    .item      (s1_item),
    .rdata     (ram_rdata),
    .wdata     (ram_wdata),
    .sums      (out_tdata),
    .frame_end (out_tlast)
  );

  assign out_tvalid = out_valid_r;

  `RGBAII_ASSERT_NXT(a_in_fills_s1, in_xfer, s1_valid_r, "accepted pixel lost before s1")
  `RGBAII_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_col),
    "stalled s1 item changed")
  `RGBAII_ASSERT_IMP(a_stall_cause, !in_tready, s1_valid_r && out_valid_r && !out_tready,
    "input stalled without a full, blocked pipe")
  `RGBAII_ASSERT_NXT(a_s1_to_out, s1_adv, out_valid_r, "s1 item not in output register")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the rgba_integral_image summed-area table block.
`timescale 1ns / 1ps
module testbench;
  import rgbaii_pkg::*;

  // Sizing of the block as instantiated (its defaults)
  localparam int MAX_DIM      = 1024;
  localparam int PIX_BITS     = NUM_LANES * PIX_W;
  localparam int OUT_BITS     = NUM_LANES * SUM_W;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_ROW     = 160;  // row 0 length of the back-to-back stretch
  localparam int SHORT_ROW    = 100;  // width the row shrinks to under it
  // About 750 pixels in all; the limit leaves a wide margin for stalls
  localparam int CYCLE_LIMIT  = 400000;

  // One expected table entry: four channel sums and the frame-end flag
  typedef struct packed {
    logic [NUM_LANES-1:0][SUM_W-1:0] sum;
    logic                            frame_end;
  } sat_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [PIX_BITS-1:0] in_tdata = '0;    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;        // [35:0] red, [71:36] green, [107:72] blue,
                                         // [143:108] alpha sums
  logic                out_tlast;        // frame_end
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  rgba_integral_image DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  logic [PIX_BITS-1:0] pix_q[$];          // pixels waiting for the driver
  sat_result_t         pending_sums[$];   // table entries not yet seen on the output
  int                  send_idle_pct  = 30;
  int                  recv_stall_pct = 30;
  bit                  pix_taken = 1'b0;  // pixel transfer at the last rising edge
  int                  mismatch_cnt = 0;
  int                  cycle_cnt = 0;
  string               lane_tag [NUM_LANES] = '{"sum_red", "sum_green", "sum_blue", "sum_alpha"};

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors registers, position counters, row sums and the
  // previous row's table values
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] reg_width  = CFG_W'(1024);
  logic [CFG_W-1:0] reg_height = CFG_W'(1024);
  logic             reg_square = 1'b0;
  logic [9:0]       pos_col = '0;
  logic [9:0]       pos_row = '0;
  logic [ROW_W-1:0] row_run [NUM_LANES] = '{default: '0};
  logic [SUM_W-1:0] prev_row_sat [MAX_DIM][NUM_LANES];

  // A size register of 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned usable_size(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Growing the row is only safe while the first row of a frame is being
  // written; later rows would read line store columns nobody has filled.
  function automatic bit width_fits(input int unsigned v);
    return (pos_row == 0) || (usable_size(v) <= usable_size(reg_width));
  endfunction

  // Computes the table entry for one accepted pixel and queues it
  function automatic void predict_sums(input logic [PIX_BITS-1:0] pix);
    sat_result_t      r;
    int unsigned      w;
    int unsigned      h;
    int               c;
    logic [ROW_W-1:0] v;
    logic [SUM_W-1:0] above;
    w = usable_size(reg_width);
    h = usable_size(reg_height);
    r = '0;
    for (c = 0; c < NUM_LANES; c++) begin
      v = ROW_W'(pix[c*PIX_W +: PIX_W]);
      if (reg_square) v = v * v;
      row_run[c] = row_run[c] + v;
      above = (pos_row == 0) ? '0 : prev_row_sat[pos_col][c];
      r.sum[c] = above + SUM_W'(row_run[c]);
      prev_row_sat[pos_col][c] = r.sum[c];
    end
    // Row and frame wrap; a shrunken size ends the row or frame at once
    if (int'(pos_col) + 1 >= int'(w)) begin
      pos_col = '0;
      for (c = 0; c < NUM_LANES; c++) row_run[c] = '0;
      if (int'(pos_row) + 1 >= int'(h)) begin
        pos_row = '0;
        r.frame_end = 1'b1;
      end else begin
        pos_row = pos_row + 1'b1;
      end
    end else begin
      pos_col = pos_col + 1'b1;
    end
    pending_sums.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Mostly random channel values, with the extremes weighted up
  function automatic logic [PIX_BITS-1:0] rand_pixel();
    logic [PIX_BITS-1:0] p;
    int                  c;
    for (c = 0; c < NUM_LANES; c++) begin
      case ($urandom_range(9))
        0:       p[c*PIX_W +: PIX_W] = '0;
        1:       p[c*PIX_W +: PIX_W] = '1;
        default: p[c*PIX_W +: PIX_W] = PIX_W'($urandom);
      endcase
    end
    return p;
  endfunction

  // Register write: one cycle of cfg_we, mirrored into the predictor.
  // Only called with the block idle, so no pixel can race the update.
  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = CFG_W'(val);
      REG_FRAME_HEIGHT: reg_height = CFG_W'(val);
      REG_SQUARE_MODE:  reg_square = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every queued pixel is in and every sum is out
  task automatic drain_all();
    while (pix_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pixels at the falling edge, holds them until transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_tvalid || pix_taken) begin
      if (rst_n && pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= pix_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each pixel transfer, checks each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    sat_result_t want;
    int          c;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL rgba_integral_image");
      $finish;
    end
    pix_taken = rst_n && in_tvalid && in_tready;
    if (pix_taken) predict_sums(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result transfer with nothing expected", 0, 0);
      end else begin
        want = pending_sums.pop_front();
        for (c = 0; c < NUM_LANES; c++) begin
          if (out_tdata[c*SUM_W +: SUM_W] !== want.sum[c])
            report_mismatch(lane_tag[c], out_tdata[c*SUM_W +: SUM_W], want.sum[c]);
        end
        if (out_tlast !== want.frame_end)
          report_mismatch("frame_end", out_tlast, want.frame_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          k;
    int          n;
    int          random_sent;
    int unsigned new_w;
    logic [PIX_BITS-1:0] px;
    random_sent = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes (1024 x 1024, plain sums): start the first row with the
    // channel extremes and a walking one through every channel bit
    pix_q.push_back('0);
    pix_q.push_back('1);
    for (k = 0; k < PIX_W; k++) pix_q.push_back({NUM_LANES{PIX_W'(1 << k)}});
    pix_q.push_back(32'hAAAA_AAAA);
    pix_q.push_back(32'h5555_5555);
    pix_q.push_back(32'hFF00_FF00);
    pix_q.push_back(32'h00FF_00FF);
    pix_q.push_back(32'h1234_5678);
    pix_q.push_back('1);
    drain_all();

    // Mid-frame changes: the row is already past the new width, so the next
    // pixel ends row 0; row 1 reads the stored table and ends the frame.
    // Square mode now mixes squared values into the running sums.
    write_reg(REG_FRAME_WIDTH, 7);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_SQUARE_MODE, 1);
    repeat (4) pix_q.push_back('1);
    repeat (4) pix_q.push_back(rand_pixel());
    drain_all();

    // Zero sizes act as 1 x 1: every pixel is a whole frame
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    repeat (3) pix_q.push_back(rand_pixel());
    drain_all();

    // Oversized height clamps to the maximum: one-pixel rows keep stacking
    write_reg(REG_FRAME_HEIGHT, (1 << CFG_W) - 1);
    repeat (3) pix_q.push_back(rand_pixel());
    drain_all();
    // Height drops below the current row: the next pixel closes the frame
    write_reg(REG_FRAME_HEIGHT, 1);
    pix_q.push_back(rand_pixel());
    drain_all();

    // Oversized width clamps to the maximum; two rows of squared values, no
    // idling on either side: back-to-back transfers throughout. Row 0 runs
    // long, then the width shrinks under it so the next pixel ends the row
    // and row 1 reads the stored table at the new width.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_FRAME_WIDTH, (1 << CFG_W) - 1);
    write_reg(REG_FRAME_HEIGHT, 2);
    repeat (LONG_ROW) pix_q.push_back(rand_pixel());
    drain_all();
    write_reg(REG_FRAME_WIDTH, SHORT_ROW);
    repeat (SHORT_ROW + 1) begin
      px = '1;
      if ($urandom_range(3) == 0) px = rand_pixel();
      pix_q.push_back(px);
    end
    drain_all();
    send_idle_pct  = 30;
    recv_stall_pct = 30;

    // Random part: small frames, settings changed between bursts, often in
    // the middle of a frame (width only grows while row 0 is in progress)
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(1)) write_reg(REG_SQUARE_MODE, $urandom_range(1));
      if ($urandom_range(1)) write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 6));
      new_w = $urandom_range(0, 12);
      if (($urandom_range(1) || random_sent == 0) && width_fits(new_w))
        write_reg(REG_FRAME_WIDTH, new_w);
      n = $urandom_range(1, 48);
      repeat (n) pix_q.push_back(rand_pixel());
      random_sent += n;
      drain_all();
    end

    // Let any stray result surface before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_sums.size() == 0) begin
      $display("PASS rgba_integral_image");
    end else begin
      $display("FAIL rgba_integral_image");
    end
    $finish;
  end

endmodule
